### rtl/sv39_page_table_walker_top_defines.svh
// Assertion macros for the Sv39 page table walker.
// No dependencies; included by the modules that carry assertions.
`ifndef SV39_PAGE_TABLE_WALKER_TOP_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge out of reset.
`define SV39PTW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define SV39PTW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SV39PTW_ASSERT(lbl, prop, msg)
`define SV39PTW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/sv39ptw_pkg.sv
// Shared types, constants and address helpers for the Sv39 walker.
// No dependencies.
package sv39ptw_pkg;

  // Table memory geometry (power of two, 512 .. 4096 words)
  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam int unsigned PPN_W  = 44;
  localparam int unsigned VPN_W  = 9;
  localparam int unsigned PTE_W  = 64;
  localparam int unsigned PA_W   = 56;
  localparam int unsigned CFG_W  = 44;

  // Request opcodes
  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROOT_PAGE    = 1'b0;
  localparam logic CFG_ROOT_PRESENT = 1'b1;

  // Leaf levels
  localparam logic [1:0] LVL_4K   = 2'd0;
  localparam logic [1:0] LVL_MEGA = 2'd1;
  localparam logic [1:0] LVL_GIGA = 2'd2;

  typedef struct packed {
    logic        op;
    logic [38:0] virtual_address;
    logic [7:0]  perm_mask;
    logic [11:0] word_index;
    logic [63:0] word_data;
  } req_t;

  typedef struct packed {
    logic [PA_W-1:0] physical_address;
    logic            page_fault;
    logic            perms_ok;
    logic [1:0]      leaf_level;
  } rsp_t;

  // Walker to table memory
  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [PTE_W-1:0]  wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  // Word of entry idx in table page, wrapped to the memory size
  function automatic logic [MEM_AW-1:0] tbl_addr(input logic [PPN_W-1:0] page,
                                                 input logic [VPN_W-1:0] idx);
    logic [PPN_W+VPN_W-1:0] full;
    full = {page, idx};
    return full[MEM_AW-1:0];
  endfunction

  function automatic logic [VPN_W-1:0] vpn_sel(input logic [38:0] va,
                                               input logic [1:0]  lvl);
    logic [VPN_W-1:0] v;
    unique case (lvl)
      LVL_4K:   v = va[20:12];
      LVL_MEGA: v = va[29:21];
      default:  v = va[38:30];
    endcase
    return v;
  endfunction

endpackage

### rtl/sv39ptw_mem.sv
// Page table word store: one write port, one read port, registered read data.
// Depends on sv39ptw_pkg.
module sv39ptw_mem
  import sv39ptw_pkg::*;
(
  input  logic             clk_i,
  input  mem_req_t         mem_i,
  output logic [PTE_W-1:0] rdata_o
);

  logic [PTE_W-1:0] mem_q [MEM_WORDS];
  logic [PTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[mem_i.waddr] <= mem_i.wdata;
    end
    if (mem_i.re) begin
      rdata_q <= mem_q[mem_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sv39ptw_walk.sv
// Walk sequencer: config registers, table write and walk loop, result registers.
// Depends on sv39ptw_pkg and sv39_page_table_walker_top_defines.svh.
`include "sv39_page_table_walker_top_defines.svh"

module sv39ptw_walk
  import sv39ptw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o,
  output mem_req_t         mem_o,
  input  logic [PTE_W-1:0] mem_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [1:0]       level_q, level_d;
  logic [38:0]      va_q, va_d;
  logic [7:0]       perms_q, perms_d;
  rsp_t             res_q, res_d;
  rsp_t             out_q;
  logic             out_valid_q, out_valid_d;
  logic [PPN_W-1:0] root_page_q;
  logic             root_present_q;

  logic             accept;
  logic             slot_free;
  logic             pte_v, pte_leaf;
  logic [PA_W-1:0]  leaf_pa;
  rsp_t             fault_rsp;

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign slot_free   = !out_valid_q || rsp_ready_i;

  assign pte_v    = mem_rdata_i[0];
  assign pte_leaf = |mem_rdata_i[3:1];

  // superpage leaves pass the low VA bits through
  always_comb begin
    unique case (level_q)
      LVL_4K:   leaf_pa = {mem_rdata_i[53:10], va_q[11:0]};
      LVL_MEGA: leaf_pa = {mem_rdata_i[53:19], va_q[20:0]};
      default:  leaf_pa = {mem_rdata_i[53:28], va_q[29:0]};
    endcase
  end

  always_comb begin
    fault_rsp            = '0;
    fault_rsp.page_fault = 1'b1;
  end

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    va_d     = va_q;
    perms_d  = perms_q;
    res_d    = res_q;
    mem_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          va_d    = req_i.virtual_address;
          perms_d = req_i.perm_mask;
          if (req_i.op == OP_WRITE) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = MEM_AW'(req_i.word_index);
            mem_o.wdata = req_i.word_data;
            res_d       = '0;
            state_d     = S_DONE;
          end else if (!root_present_q) begin
            res_d   = fault_rsp;
            state_d = S_DONE;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.raddr = tbl_addr(root_page_q, req_i.virtual_address[38:30]);
            level_d     = LVL_GIGA;
            state_d     = S_WALK;
          end
        end
      end
      S_WALK: begin
        priority if (!pte_v) begin
          res_d   = fault_rsp;
          state_d = S_DONE;
        end else if (pte_leaf) begin
          res_d.physical_address = leaf_pa;
          res_d.page_fault       = 1'b0;
          res_d.perms_ok         = ((mem_rdata_i[7:0] & perms_q) == perms_q);
          res_d.leaf_level       = level_q;
          state_d                = S_DONE;
        end else if (level_q == LVL_4K) begin
          res_d   = fault_rsp;
          state_d = S_DONE;
        end else begin
          // pointer: fetch next level entry
          level_d     = 2'(level_q - 2'd1);
          mem_o.re    = 1'b1;
          mem_o.raddr = tbl_addr(mem_rdata_i[53:10], vpn_sel(va_q, level_d));
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_DONE && slot_free) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      level_q        <= LVL_GIGA;
      out_valid_q    <= 1'b0;
      root_page_q    <= '0;
      root_present_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROOT_PAGE:    root_page_q    <= cfg_data_i;
          CFG_ROOT_PRESENT: root_present_q <= cfg_data_i[0];
          default:          root_page_q    <= root_page_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    va_q    <= va_d;
    perms_q <= perms_d;
    res_q   <= res_d;
    if (state_q == S_DONE && slot_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  `SV39PTW_ASSERT(a_no_rw_same_cycle, !(mem_o.we && mem_o.re),
                  "table read and write issued together")
  `SV39PTW_ASSERT(a_walk_has_read, (state_q == S_WALK) |-> $past(mem_o.re),
                  "walk step without a table read in flight")
  `SV39PTW_ASSERT(a_walk_level, (state_q == S_WALK) |-> (level_q != 2'd3),
                  "walk level out of range")
  `SV39PTW_ASSERT(a_no_root_faults,
                  (accept && req_i.op == OP_TRANSLATE && !root_present_q) |=>
                  (state_q == S_DONE && res_q.page_fault),
                  "translate without root did not fault")
  `SV39PTW_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !rsp_valid_o,
                         "response valid during reset")

endmodule

### rtl/sv39_page_table_walker_top.sv
// Sv39 page table walker, top level. Depends on sv39ptw_pkg, sv39ptw_mem
// and sv39ptw_walk.
//
// Usage:
//  - Config port: cfg_we_i with cfg_idx_i (0 = root table page, 1 = root
//    present) and cfg_data_i; write only while idle (the block does not enforce it).
//  - Request channel (req_valid_i/req_ready_o, req_i): op 0 stores one
//    64-bit entry word, op 1 translates a 39-bit virtual address.
//  - Response channel (rsp_valid_o/rsp_ready_i, rsp_o): one response per
//    request; writes answer all zero, faults answer page_fault only.
//  - One request at a time. A write, or a translation with no root, goes
//    from idle to the done state and from there into the output register;
//    a walk takes one walk step per table level, each waiting on a read of
//    the single table memory port. The next request is taken once the done
//    state has handed its result to the output register.
//  - The response sits in an output register; the next request is taken
//    while it waits. If the receiver stalls, a second finished result is
//    held in the walker and the request side stops until the slot frees.
//  - Reset clears the config registers and the handshake state; the
//    table memory is not cleared and must be written before it is walked.
module sv39_page_table_walker_top
  import sv39ptw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_t             req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o
);

  // walker <-> table memory
  mem_req_t         mem_req;
  logic [PTE_W-1:0] mem_rdata;

  sv39ptw_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // entry store, read data valid the cycle after the read
  sv39ptw_mem u_mem (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

### tb/sv/tb_sv39_page_table_walker_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sv39_page_table_walker_top: builds Sv39 tables, walks them
// and compares every response with a local walk predictor. Depends on sv39ptw_pkg.
module tb_sv39_page_table_walker_top;
  import sv39ptw_pkg::*;

  // Clock, reset and every DUT input start at a known value.
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = CFG_ROOT_PAGE;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             req_valid_i = 1'b0;
  logic             req_ready_o;
  req_t             req_i       = '0;
  logic             rsp_valid_o;
  logic             rsp_ready_i = 1'b0;
  rsp_t             rsp_o;

  always #5 clk_i = ~clk_i;

  sv39_page_table_walker_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  // Requests waiting to be driven, and walk results owed by the DUT, oldest first.
  req_t req_backlog[$];
  rsp_t results_due[$];

  // Register copies; only changed while the DUT is idle, so one copy serves
  // both the request planner and the predictor.
  logic [PPN_W-1:0] root_page = '0;
  logic             root_on   = 1'b0;

  // Table memory as the predictor sees it (updated on accepted writes), and as
  // the planner sees it (updated when a write is queued). The planner copy
  // keeps track of which words hold data, so no walk ever reads a blank word.
  logic [PTE_W-1:0] pte_mirror   [MEM_WORDS];
  logic [PTE_W-1:0] plan_pte     [MEM_WORDS];
  bit               plan_written [MEM_WORDS];

  logic [38:0] last_va        = '0;
  logic        calm           = 1'b0;  // no idling on either side
  int          mismatch_count = 0;
  int          send_gap       = 0;
  int          recv_stall     = 0;
  int          recv_hold      = 0;
  int          rsp_total      = 0;

  // Sv39 walk from the root register. With from_plan set it walks the planner
  // copy and stops at the first word never written, returned in blank_word
  // (-1 when the walk touched written words only).
  function automatic rsp_t walk_sv39(input logic [38:0] va, input logic [7:0] need,
                                     input bit from_plan, output logic [PTE_W-1:0] leaf,
                                     output int blank_word);
    rsp_t                   res;
    logic [PPN_W-1:0]       page;
    logic [PTE_W-1:0]       pte;
    logic [VPN_W-1:0]       vpn;
    logic [PPN_W+VPN_W-1:0] full;
    int                     w;
    bit                     done;
    res            = '0;
    res.page_fault = 1'b1;
    leaf           = '0;
    blank_word     = -1;
    done           = 1'b0;
    page           = root_page;
    if (root_on) begin
      for (int lvl = 2; lvl >= 0 && !done; lvl--) begin
        if (2'(lvl) == LVL_GIGA)      vpn = va[38:30];
        else if (2'(lvl) == LVL_MEGA) vpn = va[29:21];
        else                          vpn = va[20:12];
        full = {page, vpn};
        w    = int'(full % MEM_WORDS);  // table words wrap to the memory size
        if (from_plan && !plan_written[w]) begin
          blank_word = w;
          done       = 1'b1;
        end else begin
          pte = from_plan ? plan_pte[w] : pte_mirror[w];
          if (!pte[0]) begin
            done = 1'b1;                 // invalid entry
          end else if (pte[3:1] != 3'b000) begin
            // Leaf: superpages pass the low VA bits through, lower PPNs ignored.
            if (2'(lvl) == LVL_GIGA)
              res.physical_address = {pte[53:28], va[29:0]};
            else if (2'(lvl) == LVL_MEGA)
              res.physical_address = {pte[53:28], pte[27:19], va[20:0]};
            else
              res.physical_address = {pte[53:28], pte[27:19], pte[18:10], va[11:0]};
            res.page_fault = 1'b0;
            res.perms_ok   = ((pte[7:0] & need) == need);
            res.leaf_level = 2'(lvl);
            leaf           = pte;
            done           = 1'b1;
          end else begin
            page = pte[53:10];           // next table; a pointer at level 0 faults
          end
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Request driver: predicts each accepted request, then offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic [PTE_W-1:0] leaf_unused;
    int               blank_unused;
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
      send_gap     = 0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        if (req_i.op == OP_WRITE) begin
          pte_mirror[req_i.word_index] = req_i.word_data;
          results_due.push_back(rsp_t'(0));   // writes answer all zero
        end else begin
          results_due.push_back(walk_sv39(req_i.virtual_address, req_i.perm_mask,
                                          1'b0, leaf_unused, blank_unused));
        end
      end
      // Valid holds with a steady payload until the request is taken.
      if (!req_valid_i || req_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid_i <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req_i       <= req_backlog.pop_front();
          req_valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks field by field, stalls in short bursts, and once
  // holds off long enough for the walker to fill up and block new requests.
  always @(posedge clk_i or negedge rst_ni) begin : watch_responses
    rsp_t want;
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      recv_stall   = 0;
      recv_hold    = 0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (results_due.size() == 0) begin
          $error("response with no request outstanding");
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("physical_address", 64'(want.physical_address),
                      64'(rsp_o.physical_address));
          check_field("page_fault", 64'(want.page_fault), 64'(rsp_o.page_fault));
          check_field("perms_ok", 64'(want.perms_ok), 64'(rsp_o.perms_ok));
          check_field("leaf_level", 64'(want.leaf_level), 64'(rsp_o.leaf_level));
        end
        rsp_total++;
        if (rsp_total == 60) recv_hold = 80;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        rsp_ready_i <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rsp_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        recv_stall   = $urandom_range(0, 2);
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= 1'b1;
      end
    end
  end

  // Register write; only called with nothing in flight.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_ROOT_PAGE) root_page = val[PPN_W-1:0];
    else                      root_on   = val[0];
  endtask

  // Unused fields carry random values; the DUT must ignore them.
  task automatic queue_write(input logic [11:0] w, input logic [PTE_W-1:0] d);
    req_t r;
    r                 = '0;
    r.op              = OP_WRITE;
    r.virtual_address = 39'({$urandom, $urandom});
    r.perm_mask       = 8'($urandom);
    r.word_index      = w;
    r.word_data       = d;
    plan_pte[w]       = d;
    plan_written[w]   = 1'b1;
    req_backlog.push_back(r);
  endtask

  task automatic queue_translate(input logic [38:0] va, input logic [7:0] need);
    req_t r;
    r                 = '0;
    r.op              = OP_TRANSLATE;
    r.virtual_address = va;
    r.perm_mask       = need;
    r.word_index      = 12'($urandom);
    r.word_data       = {$urandom, $urandom};
    req_backlog.push_back(r);
  endtask

  // Random entry: half of them table pointers, so walks often reach the lower levels.
  function automatic logic [PTE_W-1:0] rand_pte();
    logic [PTE_W-1:0] d;
    int               k;
    d = {$urandom, $urandom};
    k = $urandom_range(0, 19);
    if (k < 3) begin
      d[0] = 1'b0;
    end else if (k < 10) begin
      d[0] = 1'b1;
      if (d[3:1] == 3'b000) d[3:1] = 3'($urandom_range(1, 7));
    end else begin
      d[0]   = 1'b1;
      d[3:1] = 3'b000;
    end
    return d;
  endfunction

  // Fill every blank word on the walk path with a random entry, then translate.
  task automatic plan_walk(input logic [38:0] va);
    rsp_t             res;
    logic [PTE_W-1:0] leaf;
    logic [7:0]       need;
    int               blank;
    res = walk_sv39(va, 8'h00, 1'b1, leaf, blank);
    while (blank >= 0) begin
      queue_write(12'(blank), rand_pte());
      res = walk_sv39(va, 8'h00, 1'b1, leaf, blank);
    end
    need = 8'($urandom);
    if ($urandom_range(0, 1) == 1) need &= leaf[7:0];   // often a satisfiable set
    queue_translate(va, need);
  endtask

  // Mostly walks sharing upper VPNs with the previous one, plus stray overwrites.
  task automatic random_phase(input int n);
    logic [38:0] va;
    int          k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        queue_write(12'($urandom), {$urandom, $urandom});
      end else begin
        va = 39'({$urandom, $urandom});
        if (k < 5)      va[38:21] = last_va[38:21];
        else if (k < 7) va[38:30] = last_va[38:30];
        plan_walk(va);
        last_va = va;
      end
    end
  endtask

  // Idle means: nothing left to send, valid low, no result owed.
  task automatic drain();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || req_valid_i || results_due.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset config: no root, so every translation faults without reading.
    queue_write(12'h000, 64'h0);
    queue_write(12'hFFF, '1);
    queue_translate('0, 8'h00);
    queue_translate('1, 8'hFF);
    drain();

    // Root at the top page number (wraps to the last 512 words).
    write_reg(CFG_ROOT_PAGE, '1);
    write_reg(CFG_ROOT_PRESENT, 44'h1);
    // Gigapage with every bit set; lower PPN fields must be ignored.
    queue_write(12'd3584, '1);
    queue_translate({9'd0, 30'h3FFF_FFFF}, 8'hFF);
    // Pointer to page 2, then a read-only megapage there.
    queue_write(12'd3585, {10'h0, 44'd2, 10'h001});
    queue_write(12'd1027, {10'h2AA, 44'hABC_DE12_3456, 10'h003});
    queue_translate({9'd1, 9'd3, 21'h1F_FFFF}, 8'h03);
    queue_translate({9'd1, 9'd3, 21'h0_0000}, 8'h04);
    // Pointer whose page number wraps to page 5; execute-only 4K page there.
    queue_write(12'd1028, {10'h3FF, 44'hFFF_FFFF_FFFD, 10'h001});
    queue_write(12'd3071, {10'h155, 44'h012_3456_789A, 10'h009});
    queue_translate({9'd1, 9'd4, 9'h1FF, 12'hFFF}, 8'h08);
    queue_translate({9'd1, 9'd4, 9'h1FF, 12'h000}, 8'h00);
    // Valid pointer at the last level: no leaf, fault.
    queue_write(12'd2560, {10'h0, 44'h7, 10'h001});
    queue_translate({9'd1, 9'd4, 9'h000, 12'h123}, 8'h00);
    // Invalid entries at level 0, 1 and 2.
    queue_write(12'd2562, 64'hFFFF_FFFF_FFFF_FFFE);
    queue_translate({9'd1, 9'd4, 9'h002, 12'h456}, 8'h01);
    queue_write(12'd1029, 64'h0);
    queue_translate({9'd1, 9'd5, 21'h0_1234}, 8'h01);
    queue_write(12'd3586, 64'h0);
    queue_translate({9'd2, 30'h0}, 8'h00);
    // Index 511 at the root hits the all-ones word written earlier.
    queue_translate('1, 8'hFF);
    drain();

    // Only bit 0 of the present register counts.
    write_reg(CFG_ROOT_PRESENT, 44'hFFF_FFFF_FFFE);
    queue_translate({9'd0, 30'h0}, 8'h00);
    drain();

    write_reg(CFG_ROOT_PAGE, 44'({$urandom, $urandom}));
    write_reg(CFG_ROOT_PRESENT, 44'({$urandom, $urandom}) | 44'h1);
    random_phase(50);   // the long receiver hold falls in here
    drain();

    write_reg(CFG_ROOT_PAGE, '0);
    write_reg(CFG_ROOT_PRESENT, '1);
    random_phase(50);
    drain();

    write_reg(CFG_ROOT_PRESENT, '0);
    random_phase(20);
    drain();

    write_reg(CFG_ROOT_PAGE, '1);
    write_reg(CFG_ROOT_PRESENT, 44'h1);
    random_phase(50);
    drain();

    // Final stretch at full rate on both sides.
    calm <= 1'b1;
    write_reg(CFG_ROOT_PAGE, 44'({$urandom, $urandom}));
    random_phase(50);
    drain();

    // Leave room for a stray response.
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[sv39_page_table_walker_top] OK");
    end else begin
      $display("[sv39_page_table_walker_top] ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("[sv39_page_table_walker_top] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sv39ptw_pkg.sv
rtl/sv39ptw_mem.sv
rtl/sv39ptw_walk.sv
rtl/sv39_page_table_walker_top.sv
tb/sv/tb_sv39_page_table_walker_top.sv
